// ===== rtl/time_ordered_event_queue_macros.svh =====
// Assertion macros for the time-ordered event queue.
`ifndef TIME_ORDERED_EVENT_QUEUE_MACROS_SVH
`define TIME_ORDERED_EVENT_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define TOEQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("time_ordered_event_queue check failed");
// Property checked on every clock edge, reset included.
`define TOEQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("time_ordered_event_queue check failed");
`else
`define TOEQ_ASSERT(lbl, prop)
`define TOEQ_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/toeq_pkg.sv =====
// Constants and address helpers shared by the time-ordered event queue.
`default_nettype none
package toeq_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int KIND_W      = 8;
    localparam int TIME_W      = 32;
    localparam int OCC_W       = 5;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 48;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam addr_t       LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [ADDR_W:0] DEPTH_WIDE = (ADDR_W + 1)'(QUEUE_DEPTH);

    // Circular buffer neighbors.
    function automatic addr_t addr_prev(input addr_t a);
        addr_prev = (a == '0) ? LAST_ADDR : addr_t'(a - 1'b1);
    endfunction

    function automatic addr_t addr_next(input addr_t a);
        addr_next = (a == LAST_ADDR) ? '0 : addr_t'(a + 1'b1);
    endfunction

    // Physical slot at logical offset cnt past head; cnt runs up to the depth.
    function automatic addr_t addr_offset(input addr_t head, input count_t cnt);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + (ADDR_W + 1)'(cnt);
        if (sum >= DEPTH_WIDE) begin
            sum = sum - DEPTH_WIDE;
        end
        addr_offset = sum[ADDR_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/time_ordered_event_queue.sv =====
// Time-ordered event queue: a bounded event list kept sorted by event time.
//
// Entries sit in a circular buffer held in a small single-port-write,
// registered-read memory, earliest entry at the head pointer. A remove reads
// the head slot and advances the pointer. An insert walks back from the
// tail with one shared time comparator, moving each later entry up one slot
// until it finds an entry with an equal or earlier time; each entry moved
// takes a memory read, then a compare and write. Overflowed inserts and
// removes from an empty queue go straight to the response state. One request
// is processed at a time; s_tready is high only while the sequencer is idle.
// The result register lets the next request in while a result still waits
// on m_tready.
`default_nettype none
`include "time_ordered_event_queue_macros.svh"
module time_ordered_event_queue (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [7:0] event_kind, [39:8] event_time
    input  wire logic [toeq_pkg::S_DATA_W-1:0] s_tdata,
    // [0] opcode
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] pop_kind, [39:8] pop_time, [44:40] occupancy, [45] overflow,
    // [47:46] zero
    output logic [toeq_pkg::M_DATA_W-1:0]      m_tdata,
    // [0] pop_valid
    output logic                               m_tuser
);
    import toeq_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_INS_RD    = 3'd1;
    localparam logic [2:0] ST_INS_CMP   = 3'd2;
    localparam logic [2:0] ST_INS_PLACE = 3'd3;
    localparam logic [2:0] ST_POP_RD    = 3'd4;
    localparam logic [2:0] ST_POP_OUT   = 3'd5;
    localparam logic [2:0] ST_RESP      = 3'd6;

    logic [2:0]        state_reg;
    addr_t             head_reg;
    count_t            count_reg;
    count_t            left_reg;
    addr_t             cur_reg;
    addr_t             rd_addr_reg;
    logic [KIND_W-1:0] new_kind_reg;
    logic [TIME_W-1:0] new_time_reg;

    // Result waiting for the output register.
    logic              res_valid_reg;
    logic [KIND_W-1:0] res_kind_reg;
    logic [TIME_W-1:0] res_time_reg;
    logic              res_ovf_reg;

    // Output register.
    logic              out_valid_reg;
    logic              out_pop_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic [OCC_W-1:0]  out_occ_reg;
    logic              out_ovf_reg;

    // Slot memory.
    logic [TIME_W-1:0] mem_time [QUEUE_DEPTH];
    logic [KIND_W-1:0] mem_kind [QUEUE_DEPTH];
    logic [TIME_W-1:0] rd_time_reg;
    logic [KIND_W-1:0] rd_kind_reg;

    logic              wr_en;
    addr_t             wr_addr;
    logic [TIME_W-1:0] wr_time;
    logic [KIND_W-1:0] wr_kind;

    logic              s_accept;
    logic              out_free;
    logic              later;
    logic              opcode;
    logic [KIND_W-1:0] in_kind;
    logic [TIME_W-1:0] in_time;
    addr_t             tail;

    assign opcode   = s_tuser;
    assign in_kind  = s_tdata[KIND_W-1:0];
    assign in_time  = s_tdata[KIND_W+TIME_W-1:KIND_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign later    = (rd_time_reg > new_time_reg);
    assign tail     = addr_offset(head_reg, count_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_pop_reg;
    assign m_tdata  = {2'b00, out_ovf_reg, out_occ_reg, out_time_reg, out_kind_reg};

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_time = new_time_reg;
        wr_kind = new_kind_reg;
        unique case (state_reg)
            ST_INS_CMP: begin
                wr_en = 1'b1;
                if (later) begin
                    wr_time = rd_time_reg;
                    wr_kind = rd_kind_reg;
                end
            end
            ST_INS_PLACE: begin
                wr_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_time[wr_addr] <= wr_time;
            mem_kind[wr_addr] <= wr_kind;
        end
        rd_time_reg <= mem_time[rd_addr_reg];
        rd_kind_reg <= mem_kind[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_ovf_reg   <= 1'b0;
        end else begin
            // A result taken while the next one is loaded keeps the register full.
            if (out_valid_reg && m_tready && (state_reg != ST_RESP)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        new_kind_reg  <= in_kind;
                        new_time_reg  <= in_time;
                        res_valid_reg <= 1'b0;
                        res_kind_reg  <= '0;
                        res_time_reg  <= '0;
                        res_ovf_reg   <= 1'b0;
                        if (opcode == OP_INSERT) begin
                            cur_reg     <= tail;
                            rd_addr_reg <= addr_prev(tail);
                            left_reg    <= count_reg;
                            priority if (count_reg >= COUNT_W'(QUEUE_DEPTH)) begin
                                res_ovf_reg <= 1'b1;
                                state_reg   <= ST_RESP;
                            end else if (count_reg == '0) begin
                                state_reg <= ST_INS_PLACE;
                            end else begin
                                state_reg <= ST_INS_RD;
                            end
                        end else begin
                            rd_addr_reg <= head_reg;
                            if (count_reg == '0) begin
                                state_reg <= ST_RESP;
                            end else begin
                                state_reg <= ST_POP_RD;
                            end
                        end
                    end
                end
                ST_INS_RD: begin
                    state_reg <= ST_INS_CMP;
                end
                ST_INS_CMP: begin
                    // A later entry moves up into the hole; otherwise the new
                    // entry fills the hole right behind it.
                    if (later) begin
                        cur_reg     <= rd_addr_reg;
                        rd_addr_reg <= addr_prev(rd_addr_reg);
                        left_reg    <= left_reg - 1'b1;
                        if (left_reg == count_t'(1)) begin
                            state_reg <= ST_INS_PLACE;
                        end else begin
                            state_reg <= ST_INS_RD;
                        end
                    end else begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= ST_RESP;
                    end
                end
                ST_INS_PLACE: begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= ST_RESP;
                end
                ST_POP_RD: begin
                    state_reg <= ST_POP_OUT;
                end
                ST_POP_OUT: begin
                    res_valid_reg <= 1'b1;
                    res_kind_reg  <= rd_kind_reg;
                    res_time_reg  <= rd_time_reg;
                    head_reg      <= addr_next(head_reg);
                    count_reg     <= count_reg - 1'b1;
                    state_reg     <= ST_RESP;
                end
                ST_RESP: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_pop_reg   <= res_valid_reg;
                        out_kind_reg  <= res_kind_reg;
                        out_time_reg  <= res_time_reg;
                        out_occ_reg   <= OCC_W'(count_reg);
                        out_ovf_reg   <= res_ovf_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `TOEQ_ASSERT(a_count_bound, count_reg <= COUNT_W'(QUEUE_DEPTH))
    `TOEQ_ASSERT(a_walk_has_entries, (state_reg == ST_INS_CMP) |-> (left_reg != '0))
    `TOEQ_ASSERT(a_pop_shrinks,
        (state_reg == ST_POP_OUT) |=> (count_reg == $past(count_reg) - 1'b1))
    `TOEQ_ASSERT(a_no_pop_on_overflow, !(res_valid_reg && res_ovf_reg))
    `TOEQ_ASSERT_ALWAYS(a_ready_only_idle, s_tready |-> (state_reg == ST_IDLE))
endmodule
`default_nettype wire

// ===== verif/time_ordered_event_queue_tb.sv =====
// Self-checking testbench for the time-ordered event queue: directed and random requests.
`default_nettype none
module time_ordered_event_queue_tb;
    import toeq_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 2 * QUEUE_DEPTH + 20;
    localparam int PHASE_REQS    = 325;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic              opcode;
        logic [KIND_W-1:0] ev_kind;
        logic [TIME_W-1:0] ev_time;
    } queue_req_t;

    typedef struct packed {
        logic              pop_valid;
        logic [KIND_W-1:0] pop_kind;
        logic [TIME_W-1:0] pop_time;
        logic [OCC_W-1:0]  occupancy;
        logic              overflow;
    } pop_result_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] stamp;
    } held_entry_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    wire logic           s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    wire logic           m_tvalid;
    logic                m_tready = 1'b0;
    wire logic [M_DATA_W-1:0] m_tdata;
    wire logic           m_tuser;

    queue_req_t  pending_reqs[$];
    pop_result_t expected_pops[$];
    held_entry_t sorted_events[$];
    queue_req_t  on_bus;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatches     = 0;
    int          cycle_count    = 0;

    time_ordered_event_queue i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one request to the sorted event list and returns the result it must give.
    function automatic pop_result_t apply_queue_request(input queue_req_t req);
        pop_result_t res;
        held_entry_t entry;
        int pos;
        res = '0;
        if (req.opcode == OP_INSERT) begin
            if (sorted_events.size() >= QUEUE_DEPTH) begin
                res.overflow = 1'b1;
            end else begin
                // Ties go behind every entry with an equal time.
                pos = 0;
                while (pos < sorted_events.size() &&
                       sorted_events[pos].stamp <= req.ev_time) begin
                    pos++;
                end
                entry.kind  = req.ev_kind;
                entry.stamp = req.ev_time;
                sorted_events.insert(pos, entry);
            end
        end else if (sorted_events.size() > 0) begin
            entry = sorted_events.pop_front();
            res.pop_valid = 1'b1;
            res.pop_kind  = entry.kind;
            res.pop_time  = entry.stamp;
        end
        res.occupancy = OCC_W'(sorted_events.size());
        return res;
    endfunction

    function automatic void queue_req(input logic op, input logic [KIND_W-1:0] kind,
                                      input logic [TIME_W-1:0] stamp);
        queue_req_t req;
        req.opcode  = op;
        req.ev_kind = kind;
        req.ev_time = stamp;
        pending_reqs.push_back(req);
    endfunction

    // Random requests in runs with a varying insert share, so the queue swings
    // between empty and full; a share of times comes from a small pool to force ties.
    function automatic void queue_random_reqs(input int count);
        logic [TIME_W-1:0] tie_pool[4];
        logic [TIME_W-1:0] stamp;
        int insert_pct;
        int run_left;
        run_left = 0;
        insert_pct = 50;
        foreach (tie_pool[i]) begin
            tie_pool[i] = $urandom;
        end
        tie_pool[0] = '0;
        tie_pool[3] = '1;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(60, 15);
                case ($urandom_range(2))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            run_left--;
            stamp = ($urandom_range(2) == 0) ? tie_pool[$urandom_range(3)] : $urandom;
            queue_req(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                      KIND_W'($urandom_range(255)), stamp);
        end
    endfunction

    function automatic void note_mismatch(input string what, input pop_result_t want,
                                          input pop_result_t got);
        if (mismatches < REPORT_MAX) begin
            $display("%s: expected valid=%0d kind=%02h time=%08h occ=%0d ovf=%0d,",
                     what, want.pop_valid, want.pop_kind, want.pop_time, want.occupancy,
                     want.overflow);
            $display("    got valid=%0d kind=%02h time=%08h occ=%0d ovf=%0d",
                     got.pop_valid, got.pop_kind, got.pop_time, got.occupancy,
                     got.overflow);
        end
        mismatches++;
    endfunction

    // Request driver: a new request goes out only once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_pops.push_back(apply_queue_request(on_bus));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_bus.opcode;
                    s_tdata  <= {on_bus.ev_time, on_bus.ev_kind};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        pop_result_t got;
        pop_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                got.pop_valid = m_tuser;
                got.pop_kind  = m_tdata[7:0];
                got.pop_time  = m_tdata[39:8];
                got.occupancy = m_tdata[44:40];
                got.overflow  = m_tdata[45];
                if (expected_pops.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = expected_pops.pop_front();
                    if (got.pop_valid !== want.pop_valid || got.pop_kind !== want.pop_kind ||
                        got.pop_time !== want.pop_time || got.occupancy !== want.occupancy ||
                        got.overflow !== want.overflow) begin
                        note_mismatch("result mismatch", want, got);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        // Directed: empty remove, extreme times and kinds, ties, fill to full,
        // a dropped insert at the earliest time, then removes.
        queue_req(OP_REMOVE, 8'h00, 32'h0000_0000);
        queue_req(OP_INSERT, 8'hFF, 32'hFFFF_FFFF);
        queue_req(OP_INSERT, 8'h00, 32'h0000_0000);
        queue_req(OP_INSERT, 8'h01, 32'h0000_0000);
        queue_req(OP_INSERT, 8'h02, 32'h0001_8000);
        queue_req(OP_INSERT, 8'h03, 32'hFFFF_FFFF);
        queue_req(OP_INSERT, 8'h04, 32'h0000_0001);
        for (int i = 0; i < QUEUE_DEPTH - 6; i++) begin
            queue_req(OP_INSERT, 8'h10 + i[7:0], (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555);
        end
        queue_req(OP_INSERT, 8'hEE, 32'h0000_0000);
        repeat (6) queue_req(OP_REMOVE, 8'hFF, 32'hFFFF_FFFF);
        queue_random_reqs(PHASE_REQS);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (phase > 0) begin
                queue_random_reqs(PHASE_REQS);
            end
            while (pending_reqs.size() > 0 || s_tvalid) @(posedge aclk);
        end
        while (expected_pops.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
